@@ design/mcb_pkg.sv @@
// Shared types and constants for the mouse cursor and button event generator.
package mcb_pkg;

  localparam int CW          = 12;
  localparam int DW          = CW + 1;
  localparam int MOTION_W    = 16;
  localparam int SUM_W       = MOTION_W + 2;
  localparam int NUM_BUTTONS = 4;
  localparam int NUM_EV      = NUM_BUTTONS + 1;
  localparam int BTN_W       = 2;
  localparam int KIND_W      = 2;
  localparam int MOD_W       = 3;
  localparam int CFG_IDX_W   = 2;

  localparam logic [KIND_W-1:0] EV_MOVE    = 2'd0;
  localparam logic [KIND_W-1:0] EV_PRESS   = 2'd1;
  localparam logic [KIND_W-1:0] EV_DRAG    = 2'd2;
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LOWER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_Y = 2'd3;

  localparam logic [CW-1:0] LOWER_X_RST = 12'd1;
  localparam logic [CW-1:0] LOWER_Y_RST = 12'd1;
  localparam logic [CW-1:0] UPPER_X_RST = 12'd638;
  localparam logic [CW-1:0] UPPER_Y_RST = 12'd478;

  // One event slot: what a lane (or the move check) found for the current report.
  typedef struct packed {
    logic                 valid;
    logic [KIND_W-1:0]    kind;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
  } ev_t;

endpackage

@@ design/mcb_axis.sv @@
// One cursor axis: position register plus the upper-then-lower clamp.
module mcb_axis (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic signed [mcb_pkg::MOTION_W-1:0]  motion,
  input  logic [mcb_pkg::CW-1:0]               lo,
  input  logic [mcb_pkg::CW-1:0]               hi,
  output logic [mcb_pkg::CW-1:0]               pos_new,
  output logic signed [mcb_pkg::DW-1:0]        delta
);

  logic [mcb_pkg::CW-1:0]           pos_r;
  logic signed [mcb_pkg::SUM_W-1:0] sum;
  logic signed [mcb_pkg::SUM_W-1:0] hi_s;
  logic signed [mcb_pkg::SUM_W-1:0] lo_s;
  logic signed [mcb_pkg::SUM_W-1:0] v_hi;
  logic signed [mcb_pkg::SUM_W-1:0] v_lo;

  always_comb begin
    sum  = $signed({{(mcb_pkg::SUM_W - mcb_pkg::CW){1'b0}}, pos_r})
         + $signed({{(mcb_pkg::SUM_W - mcb_pkg::MOTION_W){motion[mcb_pkg::MOTION_W-1]}},
                    motion});
    hi_s = $signed({{(mcb_pkg::SUM_W - mcb_pkg::CW){1'b0}}, hi});
    lo_s = $signed({{(mcb_pkg::SUM_W - mcb_pkg::CW){1'b0}}, lo});
    // The upper clamp runs first, so a zero upper bound can go negative here.
    v_hi = (sum >= hi_s) ? hi_s - $signed(mcb_pkg::SUM_W'(1)) : sum;
    v_lo = (v_hi <= lo_s) ? lo_s + $signed(mcb_pkg::SUM_W'(1)) : v_hi;
    pos_new = v_lo[mcb_pkg::CW-1:0];
    delta   = $signed({1'b0, pos_new}) - $signed({1'b0, pos_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (en) begin
      pos_r <= pos_new;
    end
  end

endmodule

@@ design/mcb_lane.sv @@
// One button lane: held flag, drag anchor and the press/drag/release decision.
module mcb_lane (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   down,
  input  logic [mcb_pkg::CW-1:0] pos_x,
  input  logic [mcb_pkg::CW-1:0] pos_y,
  output mcb_pkg::ev_t           ev
);

  logic                   held_r;
  logic [mcb_pkg::CW-1:0] anchor_x_r;
  logic [mcb_pkg::CW-1:0] anchor_y_r;

  always_comb begin
    ev.valid = down || held_r;
    ev.kind  = down ? (held_r ? mcb_pkg::EV_DRAG : mcb_pkg::EV_PRESS) : mcb_pkg::EV_RELEASE;
    ev.dx    = '0;
    ev.dy    = '0;
    if (down && held_r) begin
      ev.dx = $signed({1'b0, pos_x}) - $signed({1'b0, anchor_x_r});
      ev.dy = $signed({1'b0, pos_y}) - $signed({1'b0, anchor_y_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else if (en) begin
      held_r <= down;
    end
  end

  // The anchor is only read on a drag, which always follows a report with the button down that wrote it.
  always_ff @(posedge clk) begin
    if (en && down) begin
      anchor_x_r <= pos_x;
      anchor_y_r <= pos_y;
    end
  end

endmodule

@@ design/mcb_merge.sv @@
// Merge stage: holds one report's event slots and sends them out in order.
module mcb_merge (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     load,
  input  mcb_pkg::ev_t [mcb_pkg::NUM_EV-1:0]       ev_in,
  input  logic [mcb_pkg::CW-1:0]                   cursor_x,
  input  logic [mcb_pkg::CW-1:0]                   cursor_y,
  input  logic [mcb_pkg::MOD_W-1:0]                mods,
  output logic                                     free,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [mcb_pkg::KIND_W-1:0]               out_event_kind,
  output logic [mcb_pkg::BTN_W-1:0]                out_button_index,
  output logic [mcb_pkg::CW-1:0]                   out_cursor_x,
  output logic [mcb_pkg::CW-1:0]                   out_cursor_y,
  output logic signed [mcb_pkg::DW-1:0]            out_delta_x,
  output logic signed [mcb_pkg::DW-1:0]            out_delta_y,
  output logic [mcb_pkg::MOD_W-1:0]                out_event_modifiers,
  output logic                                     out_last_event
);

  logic [mcb_pkg::NUM_EV-1:0]         pend_r;
  logic [mcb_pkg::NUM_EV-1:0]         pend_nxt;
  logic [mcb_pkg::NUM_EV-1:0]         sel;
  logic [mcb_pkg::NUM_EV-1:0]         load_mask;
  mcb_pkg::ev_t [mcb_pkg::NUM_EV-1:0] slot_r;
  logic [mcb_pkg::CW-1:0]             cx_r;
  logic [mcb_pkg::CW-1:0]             cy_r;
  logic [mcb_pkg::MOD_W-1:0]          mods_r;
  logic                               xfer;

  always_comb begin
    for (int i = 0; i < mcb_pkg::NUM_EV; i++) begin
      load_mask[i] = ev_in[i].valid;
    end
  end

  // Lowest pending slot goes next: the move slot, then buttons in index order.
  always_comb begin
    sel                 = pend_r & (~pend_r + mcb_pkg::NUM_EV'(1));
    out_event_kind      = '0;
    out_button_index    = '0;
    out_delta_x         = '0;
    out_delta_y         = '0;
    for (int i = 0; i < mcb_pkg::NUM_EV; i++) begin
      if (sel[i]) begin
        out_event_kind = slot_r[i].kind;
        out_delta_x    = slot_r[i].dx;
        out_delta_y    = slot_r[i].dy;
        if (i > 0) begin
          out_button_index = mcb_pkg::BTN_W'(i - 1);
        end
      end
    end
    out_valid           = |pend_r;
    out_last_event      = ((pend_r & ~sel) == '0);
    out_cursor_x        = cx_r;
    out_cursor_y        = cy_r;
    out_event_modifiers = mods_r;
    xfer                = out_valid && !out_stall;
    free                = !out_valid || (xfer && out_last_event);
    if (load) begin
      pend_nxt = load_mask;
    end else if (xfer) begin
      pend_nxt = pend_r & ~sel;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= ev_in;
      cx_r   <= cursor_x;
      cy_r   <= cursor_y;
      mods_r <= mods;
    end
  end

endmodule

@@ design/mouse_cursor_button_event_gen.sv @@
// Top level of the mouse cursor and button event generator.
// A report transfer is taken in any cycle in which the clamp stage is free; the clamped
// cursor moves on at that edge. The second stage registers the clamped report; from it
// the four button lanes decide their events in parallel and the merge stage loads the
// whole report at once. Events leave one per cycle on the single result port while it
// does not stall, so a report yields 0 to 5 events. While the merge stage drains one
// report the next is already clamped and waiting. No clearing pass follows reset.
module mouse_cursor_button_event_gen (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mcb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mcb_pkg::CW-1:0]               cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mcb_pkg::MOTION_W-1:0]  in_motion_x,
  input  logic signed [mcb_pkg::MOTION_W-1:0]  in_motion_y,
  input  logic [mcb_pkg::NUM_BUTTONS-1:0]      in_button_bits,
  input  logic [mcb_pkg::MOD_W-1:0]            in_modifier_bits,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mcb_pkg::KIND_W-1:0]           out_event_kind,
  output logic [mcb_pkg::BTN_W-1:0]            out_button_index,
  output logic [mcb_pkg::CW-1:0]               out_cursor_x,
  output logic [mcb_pkg::CW-1:0]               out_cursor_y,
  output logic signed [mcb_pkg::DW-1:0]        out_delta_x,
  output logic signed [mcb_pkg::DW-1:0]        out_delta_y,
  output logic [mcb_pkg::MOD_W-1:0]            out_event_modifiers,
  output logic                                 out_last_event
);

  logic [mcb_pkg::CW-1:0] lower_x_r;
  logic [mcb_pkg::CW-1:0] lower_y_r;
  logic [mcb_pkg::CW-1:0] upper_x_r;
  logic [mcb_pkg::CW-1:0] upper_y_r;

  logic                                 in_xfer;
  logic                                 s2_adv;
  logic                                 merge_free;
  logic [mcb_pkg::CW-1:0]               pos_x_new;
  logic [mcb_pkg::CW-1:0]               pos_y_new;
  logic signed [mcb_pkg::DW-1:0]        dx_new;
  logic signed [mcb_pkg::DW-1:0]        dy_new;

  logic                                 s2_valid_r;
  logic [mcb_pkg::CW-1:0]               s2_x_r;
  logic [mcb_pkg::CW-1:0]               s2_y_r;
  logic signed [mcb_pkg::DW-1:0]        s2_dx_r;
  logic signed [mcb_pkg::DW-1:0]        s2_dy_r;
  logic                                 s2_moved_r;
  logic [mcb_pkg::NUM_BUTTONS-1:0]      s2_buttons_r;
  logic [mcb_pkg::MOD_W-1:0]            s2_mods_r;

  mcb_pkg::ev_t [mcb_pkg::NUM_EV-1:0]   ev_all;

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_x_r <= mcb_pkg::LOWER_X_RST;
      lower_y_r <= mcb_pkg::LOWER_Y_RST;
      upper_x_r <= mcb_pkg::UPPER_X_RST;
      upper_y_r <= mcb_pkg::UPPER_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mcb_pkg::REG_LOWER_X: lower_x_r <= cfg_wdata;
        mcb_pkg::REG_LOWER_Y: lower_y_r <= cfg_wdata;
        mcb_pkg::REG_UPPER_X: upper_x_r <= cfg_wdata;
        mcb_pkg::REG_UPPER_Y: upper_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s2_adv   = s2_valid_r && merge_free;
  assign in_stall = s2_valid_r && !s2_adv;
  assign in_xfer  = in_valid && !in_stall;

  mcb_axis u_axis_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (in_xfer),
    .motion  (in_motion_x),
    .lo      (lower_x_r),
    .hi      (upper_x_r),
    .pos_new (pos_x_new),
    .delta   (dx_new)
  );

  mcb_axis u_axis_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (in_xfer),
    .motion  (in_motion_y),
    .lo      (lower_y_r),
    .hi      (upper_y_r),
    .pos_new (pos_y_new),
    .delta   (dy_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s2_valid_r <= 1'b1;
    end else if (s2_adv) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s2_x_r       <= pos_x_new;
      s2_y_r       <= pos_y_new;
      s2_dx_r      <= dx_new;
      s2_dy_r      <= dy_new;
      s2_moved_r   <= (dx_new != '0) || (dy_new != '0);
      s2_buttons_r <= in_button_bits;
      s2_mods_r    <= in_modifier_bits;
    end
  end

  always_comb begin
    ev_all[0].valid = s2_moved_r;
    ev_all[0].kind  = mcb_pkg::EV_MOVE;
    ev_all[0].dx    = s2_dx_r;
    ev_all[0].dy    = s2_dy_r;
  end

  for (genvar g = 0; g < mcb_pkg::NUM_BUTTONS; g++) begin : g_lane
    mcb_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (s2_adv),
      .down  (s2_buttons_r[g]),
      .pos_x (s2_x_r),
      .pos_y (s2_y_r),
      .ev    (ev_all[g + 1])
    );
  end

  mcb_merge u_merge (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (s2_adv),
    .ev_in               (ev_all),
    .cursor_x            (s2_x_r),
    .cursor_y            (s2_y_r),
    .mods                (s2_mods_r),
    .free                (merge_free),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_kind      (out_event_kind),
    .out_button_index    (out_button_index),
    .out_cursor_x        (out_cursor_x),
    .out_cursor_y        (out_cursor_y),
    .out_delta_x         (out_delta_x),
    .out_delta_y         (out_delta_y),
    .out_event_modifiers (out_event_modifiers),
    .out_last_event      (out_last_event)
  );

endmodule

@@ design/mcb_checker.sv @@
// Port-level checks for the mouse cursor and button event generator, bound to the top.
module mcb_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [mcb_pkg::KIND_W-1:0]           out_event_kind,
  input logic [mcb_pkg::BTN_W-1:0]            out_button_index,
  input logic [mcb_pkg::CW-1:0]               out_cursor_x,
  input logic [mcb_pkg::CW-1:0]               out_cursor_y,
  input logic signed [mcb_pkg::DW-1:0]        out_delta_x,
  input logic signed [mcb_pkg::DW-1:0]        out_delta_y,
  input logic [mcb_pkg::MOD_W-1:0]            out_event_modifiers,
  input logic                                 out_last_event
);

  // A held result transfer must not change its kind, button, offsets or last flag under stall.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind)
      && $stable(out_button_index) && $stable(out_delta_x) && $stable(out_delta_y)
      && $stable(out_last_event))
    else $error("result changed while stalled");

  // Press and release carry no offset.
  a_press_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == mcb_pkg::EV_PRESS
      || out_event_kind == mcb_pkg::EV_RELEASE)
    |-> out_delta_x == '0 && out_delta_y == '0)
    else $error("press or release with nonzero delta");

  // A move names no button and really moves.
  a_move_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == mcb_pkg::EV_MOVE
    |-> out_button_index == '0 && (out_delta_x != '0 || out_delta_y != '0))
    else $error("malformed move event");

  // Events of one report follow each other directly and share cursor and modifiers.
  a_report_shared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_event
    |=> out_valid && $stable(out_cursor_x) && $stable(out_cursor_y)
      && $stable(out_event_modifiers))
    else $error("events of one report disagree");

endmodule

bind mouse_cursor_button_event_gen mcb_checker u_mcb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_event_kind      (out_event_kind),
  .out_button_index    (out_button_index),
  .out_cursor_x        (out_cursor_x),
  .out_cursor_y        (out_cursor_y),
  .out_delta_x         (out_delta_x),
  .out_delta_y         (out_delta_y),
  .out_event_modifiers (out_event_modifiers),
  .out_last_event      (out_last_event)
);
